// File: sv/word_alu_fifteen_ops_unit_assert.svh
// Assertion macros for the word ALU pipeline.
// Used by word_alu_fifteen_ops_unit; expects aclk and aresetn in scope.
`ifndef WORD_ALU_FIFTEEN_OPS_UNIT_ASSERT_SVH
`define WORD_ALU_FIFTEEN_OPS_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define WAFO_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define WAFO_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: sv/wafo_pkg.sv
// Shared types and codes for the word ALU pipeline.
// No dependencies; imported by every module of the block.
package wafo_pkg;

    localparam int DATA_W    = 64;
    localparam int HALF_W    = DATA_W / 2;
    localparam int MAX_WIDTH = 64;
    localparam int WS_W      = 7;
    localparam int SH_W      = 7;
    localparam int OP_W      = 4;
    localparam int CMP_W     = 3;

    // Operation codes
    localparam logic [OP_W-1:0] OP_AND   = 4'd0;
    localparam logic [OP_W-1:0] OP_NAND  = 4'd1;
    localparam logic [OP_W-1:0] OP_OR    = 4'd2;
    localparam logic [OP_W-1:0] OP_NOR   = 4'd3;
    localparam logic [OP_W-1:0] OP_XOR   = 4'd4;
    localparam logic [OP_W-1:0] OP_XNOR  = 4'd5;
    localparam logic [OP_W-1:0] OP_SUB   = 4'd6;
    localparam logic [OP_W-1:0] OP_ADD   = 4'd7;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd8;
    localparam logic [OP_W-1:0] OP_NOT   = 4'd9;
    localparam logic [OP_W-1:0] OP_SHL   = 4'd10;
    localparam logic [OP_W-1:0] OP_SHR   = 4'd11;
    localparam logic [OP_W-1:0] OP_MUX   = 4'd12;
    localparam logic [OP_W-1:0] OP_CMP   = 4'd13;
    localparam logic [OP_W-1:0] OP_CONST = 4'd14;

    // Compare modes, unsigned
    localparam logic [CMP_W-1:0] CMP_EQ = 3'd0;
    localparam logic [CMP_W-1:0] CMP_LT = 3'd1;
    localparam logic [CMP_W-1:0] CMP_GT = 3'd2;
    localparam logic [CMP_W-1:0] CMP_GE = 3'd3;
    localparam logic [CMP_W-1:0] CMP_LE = 3'd4;
    localparam logic [CMP_W-1:0] CMP_NE = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   req_type;
        logic [WS_W-1:0]   word_size;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic [DATA_W-1:0] operand_c;
        logic [SH_W-1:0]   shift_dist;
        logic [CMP_W-1:0]  compare_mode;
        logic [DATA_W-1:0] immediate;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              bad_request;
    } rsp_t;

    // Between the execute and finish stages
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] mask;
        logic              bad;
        logic              is_mul;
        logic [DATA_W-1:0] pp_ll;
        logic [HALF_W-1:0] pp_lh;
        logic [HALF_W-1:0] pp_hl;
    } mid_t;

endpackage

// File: sv/word_alu_fifteen_ops_unit.sv
// Word ALU, three register stages: input, execute, result.
// Throughput: one item per cycle while m_ready does not stall the output;
// the 64-bit multiply is split into 32x32 partial products in execute and
// summed in finish, which sets the depth.
// Reset (aresetn, synchronous, active low) clears the stage valid bits only.
module word_alu_fifteen_ops_unit import wafo_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_req,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_rsp
);

    logic req_valid_reg;
    logic mid_valid_reg;
    logic out_valid_reg;
    req_t req_reg;
    mid_t mid_reg;
    rsp_t out_reg;
    mid_t mid_next;
    rsp_t out_next;
    logic out_ready;
    logic mid_ready;

    // Each stage moves on when the one after it is empty or moving
    assign out_ready = !out_valid_reg || m_ready;
    assign mid_ready = !mid_valid_reg || out_ready;
    assign s_ready   = !req_valid_reg || mid_ready;

    wafo_exec u_exec (
        .req (req_reg),
        .mid (mid_next)
    );

    wafo_finish u_finish (
        .mid (mid_reg),
        .rsp (out_next)
    );

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                req_valid_reg <= s_valid;
            end
            if (mid_ready) begin
                mid_valid_reg <= req_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            req_reg <= s_req;
        end
        if (mid_ready && req_valid_reg) begin
            mid_reg <= mid_next;
        end
        if (out_ready && mid_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_rsp   = out_reg;

    // Checks
    `include "word_alu_fifteen_ops_unit_assert.svh"

    `WAFO_ASSERT_NOW(a_bad_gives_zero, m_valid && m_rsp.bad_request, m_rsp.result == '0, "bad item with nonzero result")
    `WAFO_ASSERT_NEXT(a_accept_fills_input, s_valid && s_ready, req_valid_reg, "accepted item not captured")
    `WAFO_ASSERT_NEXT(a_input_holds_on_stall, req_valid_reg && !mid_ready, req_valid_reg && $stable(req_reg), "stalled item lost or overwritten")

endmodule

// File: sv/wafo_exec.sv
// Execute stage: operand masking, all non-multiply ops and multiply partial products.
// Depends on wafo_pkg.
module wafo_exec import wafo_pkg::*; (
    input  req_t req,
    output mid_t mid
);

    logic [WS_W-1:0]   ws_c;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
    logic [DATA_W-1:0] value;
    logic              bad;
    logic              cmp_bit;

    // Clamp the word size and build its mask
    assign ws_c = (req.word_size > WS_W'(MAX_WIDTH)) ? WS_W'(MAX_WIDTH) : req.word_size;
    assign mask = ~({DATA_W{1'b1}} << ws_c);
    assign a    = req.operand_a & mask;
    assign b    = req.operand_b & mask;
    assign c    = req.operand_c & mask;

    // Operation select
    always_comb begin
        value   = '0;
        bad     = 1'b0;
        cmp_bit = 1'b0;
        case (req.req_type)
            OP_AND:   value = a & b;
            OP_NAND:  value = ~(a & b);
            OP_OR:    value = a | b;
            OP_NOR:   value = ~(a | b);
            OP_XOR:   value = a ^ b;
            OP_XNOR:  value = ~(a ^ b);
            OP_SUB:   value = a - b;
            OP_ADD:   value = a + b;
            OP_MUL:   value = '0;
            OP_NOT:   value = ~a;
            OP_SHL:   value = (req.shift_dist >= ws_c) ? '0 : (a << req.shift_dist);
            OP_SHR:   value = (req.shift_dist >= ws_c) ? '0 : (a >> req.shift_dist);
            OP_MUX:   value = req.operand_a[0] ? b : c;
            OP_CMP: begin
                case (req.compare_mode)
                    CMP_EQ:  cmp_bit = (a == b);
                    CMP_LT:  cmp_bit = (a < b);
                    CMP_GT:  cmp_bit = (a > b);
                    CMP_GE:  cmp_bit = (a >= b);
                    CMP_LE:  cmp_bit = (a <= b);
                    CMP_NE:  cmp_bit = (a != b);
                    default: bad = 1'b1;
                endcase
                value = DATA_W'(cmp_bit);
            end
            OP_CONST: value = req.immediate;
            default:  bad = 1'b1;
        endcase
    end

    // Low-word product split into 32x32 partial products; cross terms need low half only
    assign mid.pp_ll  = DATA_W'(a[HALF_W-1:0]) * DATA_W'(b[HALF_W-1:0]);
    assign mid.pp_lh  = a[HALF_W-1:0] * b[DATA_W-1:HALF_W];
    assign mid.pp_hl  = a[DATA_W-1:HALF_W] * b[HALF_W-1:0];
    assign mid.value  = value;
    assign mid.mask   = mask;
    assign mid.bad    = bad;
    assign mid.is_mul = (req.req_type == OP_MUL);

endmodule

// File: sv/wafo_finish.sv
// Finish stage: sums the multiply partial products, selects and masks the result.
// Depends on wafo_pkg.
module wafo_finish import wafo_pkg::*; (
    input  mid_t mid,
    output rsp_t rsp
);

    logic [HALF_W-1:0] cross_sum;
    logic [DATA_W-1:0] product;
    logic [DATA_W-1:0] value;

    // Cross terms land in the upper half only
    assign cross_sum = mid.pp_lh + mid.pp_hl;
    assign product   = mid.pp_ll + {cross_sum, {HALF_W{1'b0}}};
    assign value     = mid.is_mul ? product : mid.value;

    assign rsp.result      = value & mid.mask;
    assign rsp.bad_request = mid.bad;

endmodule

// File: tb/word_alu_fifteen_ops_unit_tb.sv
// Self-checking testbench for word_alu_fifteen_ops_unit: directed and random requests,
// each result checked against an in-line ALU predictor.
// Depends on wafo_pkg (request and response types, operation codes) and the unit itself.
module word_alu_fifteen_ops_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wafo_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;

    // Codes the block must reject
    localparam logic [OP_W-1:0]  OP_BAD     = 4'd15;
    localparam logic [CMP_W-1:0] CMP_BAD_LO = 3'd6;
    localparam logic [CMP_W-1:0] CMP_BAD_HI = 3'd7;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_req = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_rsp;

    req_t pending_req[$];
    rsp_t expected_rsp[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned cycle_count = 0;
    int fault_count = 0;

    word_alu_fifteen_ops_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Expected response for one request
    function automatic rsp_t alu_result(req_t rq);
        int unsigned ws;
        logic [DATA_W-1:0] m, a, b, c, r;
        logic bad;
        rsp_t rsp;
        ws = rq.word_size;
        if (ws > MAX_WIDTH) ws = MAX_WIDTH;
        if (ws == 0) m = '0;
        else if (ws >= DATA_W) m = '1;
        else m = (64'd1 << ws) - 64'd1;
        a = rq.operand_a & m;
        b = rq.operand_b & m;
        c = rq.operand_c & m;
        r = '0;
        bad = 1'b0;
        case (rq.req_type)
            OP_AND:   r = a & b;
            OP_NAND:  r = ~(a & b);
            OP_OR:    r = a | b;
            OP_NOR:   r = ~(a | b);
            OP_XOR:   r = a ^ b;
            OP_XNOR:  r = ~(a ^ b);
            OP_SUB:   r = a - b;
            OP_ADD:   r = a + b;
            OP_MUL:   r = a * b;
            OP_NOT:   r = ~a;
            OP_SHL:   r = (rq.shift_dist >= ws) ? '0 : (a << rq.shift_dist);
            OP_SHR:   r = (rq.shift_dist >= ws) ? '0 : (a >> rq.shift_dist);
            // select is bit 0 of the raw operand, before truncation
            OP_MUX:   r = rq.operand_a[0] ? b : c;
            OP_CMP: begin
                case (rq.compare_mode)
                    CMP_EQ:  r = {63'd0, a == b};
                    CMP_LT:  r = {63'd0, a < b};
                    CMP_GT:  r = {63'd0, a > b};
                    CMP_GE:  r = {63'd0, a >= b};
                    CMP_LE:  r = {63'd0, a <= b};
                    CMP_NE:  r = {63'd0, a != b};
                    default: bad = 1'b1;
                endcase
            end
            OP_CONST: r = rq.immediate;
            default:  bad = 1'b1;
        endcase
        rsp.result = r & m;
        rsp.bad_request = bad;
        return rsp;
    endfunction

    task automatic add_req(logic [OP_W-1:0] op, logic [WS_W-1:0] ws, logic [DATA_W-1:0] a,
                           logic [DATA_W-1:0] b, logic [DATA_W-1:0] c, logic [SH_W-1:0] sh,
                           logic [CMP_W-1:0] mode, logic [DATA_W-1:0] imm);
        req_t rq;
        rq.req_type = op;
        rq.word_size = ws;
        rq.operand_a = a;
        rq.operand_b = b;
        rq.operand_c = c;
        rq.shift_dist = sh;
        rq.compare_mode = mode;
        rq.immediate = imm;
        pending_req.push_back(rq);
    endtask

    // Operand with a bias towards corner values
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(63);
            3: return {32'd0, 24'd0, 8'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic add_random(int count);
        req_t rq;
        int unsigned ws_eff;
        for (int n = 0; n < count; n++) begin
            rq.req_type = OP_W'($urandom_range(15));
            case ($urandom_range(19))
                0: rq.word_size = '0;
                1: rq.word_size = WS_W'($urandom_range(127, 65));
                2, 3: rq.word_size = 7'd64;
                default: rq.word_size = WS_W'($urandom_range(64, 1));
            endcase
            ws_eff = (rq.word_size > MAX_WIDTH) ? MAX_WIDTH : rq.word_size;
            rq.operand_a = rand_word();
            rq.operand_b = rand_word();
            rq.operand_c = rand_word();
            // equal operands, sometimes differing only above the word
            case ($urandom_range(5))
                0: rq.operand_b = rq.operand_a;
                1: rq.operand_b = rq.operand_a ^ 64'h8000_0000_0000_0000;
                default: ;
            endcase
            if ($urandom_range(3) == 0) rq.shift_dist = SH_W'($urandom_range(127));
            else rq.shift_dist = SH_W'($urandom_range(ws_eff + 1));
            rq.compare_mode = CMP_W'($urandom_range(7));
            rq.immediate = rand_word();
            pending_req.push_back(rq);
        end
    endtask

    // Sender pause: nothing queued, nothing in flight
    task automatic drain();
        while (pending_req.size() != 0 || s_valid || expected_rsp.size() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        add_random(count);
        drain();
    endtask

    // Request driver, fed from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) expected_rsp.push_back(alu_result(s_req));
            if (s_valid && !s_ready) begin
                // item still on offer, hold it
            end else if (pending_req.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_req <= pending_req.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Response monitor
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected item: result %h bad %b",
                         $time, m_rsp.result, m_rsp.bad_request);
                fault_count++;
            end else begin
                want = expected_rsp.pop_front();
                if (m_rsp.result !== want.result) begin
                    $display("%0t: result mismatch: expected %h actual %h",
                             $time, want.result, m_rsp.result);
                    fault_count++;
                end
                if (m_rsp.bad_request !== want.bad_request) begin
                    $display("%0t: bad_request mismatch: expected %b actual %b",
                             $time, want.bad_request, m_rsp.bad_request);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed corners, no idling
        add_req(OP_AND,   7'd64,  '1, '1, '0, 7'd0, CMP_EQ, '0);
        add_req(OP_NAND,  7'd1,   64'd1, 64'd3, '0, 7'd0, CMP_EQ, '0);
        add_req(OP_OR,    7'd0,   '1, '1, '1, 7'd0, CMP_EQ, '1);
        add_req(OP_NOR,   7'd127, '0, '0, '0, 7'd0, CMP_EQ, '0);
        add_req(OP_XOR,   7'd64,  64'hF0F0_F0F0_0F0F_0F0F, '1, '0, 7'd0, CMP_EQ, '0);
        add_req(OP_XNOR,  7'd8,   64'hFFFF_FFFF_FFFF_FF5A, 64'h0F, '0, 7'd0, CMP_EQ, '0);
        add_req(OP_SUB,   7'd64,  '0, 64'd1, '0, 7'd0, CMP_EQ, '0);
        add_req(OP_ADD,   7'd64,  '1, 64'd1, '0, 7'd0, CMP_EQ, '0);
        add_req(OP_MUL,   7'd64,  '1, '1, '0, 7'd0, CMP_EQ, '0);
        add_req(OP_NOT,   7'd33,  64'h1_0000_0000, '0, '0, 7'd0, CMP_EQ, '0);
        add_req(OP_SHL,   7'd64,  '1, '0, '0, 7'd63, CMP_EQ, '0);
        add_req(OP_SHL,   7'd64,  '1, '0, '0, 7'd64, CMP_EQ, '0);
        add_req(OP_SHR,   7'd16,  '1, '0, '0, 7'd15, CMP_EQ, '0);
        add_req(OP_SHR,   7'd16,  '1, '0, '0, 7'd127, CMP_EQ, '0);
        add_req(OP_MUX,   7'd8,   64'hFF01, 64'h1AB, 64'h2CD, 7'd0, CMP_EQ, '0);
        add_req(OP_MUX,   7'd8,   64'hFF00, 64'h1AB, 64'h2CD, 7'd0, CMP_EQ, '0);
        // operands equal below the word size, different above it
        add_req(OP_CMP,   7'd16,  64'h1_1234, 64'h2_1234, '0, 7'd0, CMP_EQ, '0);
        add_req(OP_CMP,   7'd64,  '0, '1, '0, 7'd0, CMP_LT, '0);
        add_req(OP_CMP,   7'd64,  '1, '0, '0, 7'd0, CMP_GT, '0);
        add_req(OP_CMP,   7'd16,  64'h1_1234, 64'h2_1234, '0, 7'd0, CMP_GE, '0);
        add_req(OP_CMP,   7'd16,  64'h0_FFFF, 64'h1_0000, '0, 7'd0, CMP_LE, '0);
        add_req(OP_CMP,   7'd64,  64'd5, 64'd5, '0, 7'd0, CMP_NE, '0);
        add_req(OP_CMP,   7'd64,  64'd5, 64'd6, '0, 7'd0, CMP_BAD_LO, '0);
        add_req(OP_CMP,   7'd0,   64'd5, 64'd6, '0, 7'd0, CMP_BAD_HI, '0);
        add_req(OP_CONST, 7'd65,  '0, '0, '0, 7'd0, CMP_EQ, '1);
        add_req(OP_BAD,   7'd64,  '1, '1, '1, 7'd127, CMP_BAD_HI, '1);
        drain();

        // Random traffic under each idling pattern
        run_phase(0, 0, 300);
        run_phase(78, 0, 250);
        run_phase(0, 78, 250);
        run_phase(25, 25, 200);

        // Long receiver hold-off with the sender pushing flat out
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request <= 1'b1;
        add_random(100);
        drain();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
